[src/filtered_trace_capture_ring_defines.svh]
// assertion macros for the trace capture ring
`ifndef FILTERED_TRACE_CAPTURE_RING_DEFINES_SVH
`define FILTERED_TRACE_CAPTURE_RING_DEFINES_SVH

// implication in the same cycle
`define FTCR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ftcr check failed");

// implication in the next cycle
`define FTCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ftcr check failed");

`endif

[src/ftcr_pkg.sv]
// shared constants, types and helpers of the trace capture ring
package ftcr_pkg;

  localparam int RING_DEPTH = 128;
  localparam int MAX_BYTES  = 128;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int PAY_DEPTH  = RING_DEPTH * MAX_BYTES;
  localparam int PAY_AW     = $clog2(PAY_DEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] IDX_NONE = 8'hFF;

  typedef enum logic [2:0] {
    OP_HDR        = 3'd0,
    OP_PAIR       = 3'd1,
    OP_BYTE       = 3'd2,
    OP_DRAIN_HDR  = 3'd3,
    OP_DRAIN_BYTE = 3'd4
  } op_e;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_PAIR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NFC_STATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_KIND  = 3'd4;

  localparam logic [15:0] NFC_H0 = 16'h0014;
  localparam logic [15:0] NFC_H1 = 16'h001A;
  localparam logic [15:0] NFC_H2 = 16'h001B;
  localparam logic [15:0] NFC_H3 = 16'h0016;
  localparam logic [15:0] NFC_H4 = 16'h001E;
  localparam logic [15:0] NFC_H5 = 16'h001F;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  kind;
    logic [15:0] handle;
    logic [15:0] record_len;
    logic [63:0] timestamp_us;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        entry_valid;
    logic [7:0]  entry_kind;
    logic [15:0] entry_handle;
    logic [63:0] entry_time_us;
    logic [15:0] entry_orig_len;
    logic [7:0]  entry_stored_len;
    logic [7:0]  data_out;
    logic [6:0]  buffered_count;
    logic [31:0] dropped_count;
  } result_t;

  function automatic logic nfc_handle(logic [15:0] h);
    return (h == NFC_H0) || (h == NFC_H1) || (h == NFC_H2) ||
           (h == NFC_H3) || (h == NFC_H4) || (h == NFC_H5);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

[src/ftcr_in_if.sv]
// input channel of the trace capture ring
interface ftcr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  kind;
  logic [15:0] handle;
  logic [15:0] record_len;
  logic [63:0] timestamp_us;
  logic [7:0]  data_byte;

  modport source (output valid, operation, kind, handle, record_len, timestamp_us,
                  data_byte, input ready);
  modport sink (input valid, operation, kind, handle, record_len, timestamp_us,
                data_byte, output ready);
endinterface

[src/ftcr_out_if.sv]
// result channel of the trace capture ring
interface ftcr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        entry_valid;
  logic [7:0]  entry_kind;
  logic [15:0] entry_handle;
  logic [63:0] entry_time_us;
  logic [15:0] entry_orig_len;
  logic [7:0]  entry_stored_len;
  logic [7:0]  data_out;
  logic [6:0]  buffered_count;
  logic [31:0] dropped_count;

  modport source (output valid, accepted, entry_valid, entry_kind, entry_handle,
                  entry_time_us, entry_orig_len, entry_stored_len, data_out,
                  buffered_count, dropped_count, input ready);
  modport sink (input valid, accepted, entry_valid, entry_kind, entry_handle,
                entry_time_us, entry_orig_len, entry_stored_len, data_out,
                buffered_count, dropped_count, output ready);
endinterface

[src/ftcr_ctrl.sv]
// two-state sequencer of the trace capture ring
module ftcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  ftcr_pkg::status_t status_i,
  output logic              in_ready_o,
  output ftcr_pkg::cmd_t    cmd_o
);

  ftcr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftcr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ftcr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ftcr_pkg::ST_RUN;
      end
      ftcr_pkg::ST_RUN: begin
        if (!status_i.out_full || out_ready_i) state_d = ftcr_pkg::ST_IDLE;
      end
      default: state_d = ftcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.take   = out_ready_i;
    case (state_q)
      ftcr_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ftcr_pkg::ST_RUN: begin
        cmd_o.exec = !status_i.out_full || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[src/ftcr_datapath.sv]
// pointers, stores, settings and result register of the trace capture ring
module ftcr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ftcr_pkg::cmd_t                      cmd_i,
  input  ftcr_pkg::in_item_t                  item_i,
  input  logic                                cfg_we_i,
  input  logic [ftcr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ftcr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ftcr_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output ftcr_pkg::result_t                   result_o
);

  localparam int PW = ftcr_pkg::PTR_W;
  localparam int AW = ftcr_pkg::PAY_AW;

  // settings
  logic [1:0] mode_q;
  logic       filter_q;
  logic [7:0] marker_q, nfc_kind_q, pair_kind_q;
  logic       clear_ring;

  // pointers and counters
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
  logic [7:0]    widx_q, widx_d, ridx_q, ridx_d;
  logic [7:0]    wlen_q, wlen_d, rlen_q, rlen_d;
  logic [31:0]   drop_q, drop_d;

  // stores
  logic [63:0] time_mem [ftcr_pkg::RING_DEPTH];
  logic [47:0] meta_mem [ftcr_pkg::RING_DEPTH];
  logic [7:0]  pay_mem  [ftcr_pkg::PAY_DEPTH];
  logic [63:0] time_rd_q;
  logic [47:0] meta_rd_q;
  logic [7:0]  pay_rd_q;

  ftcr_pkg::in_item_t it_q;
  ftcr_pkg::result_t  res_q, res_d;
  logic               out_valid_q;

  logic          is_hdr, is_pair, pass_hdr, pass_pair, store, byte_ok, drain_ok, rbyte_ok;
  logic          full;
  logic [PW-1:0] head_nx;
  logic [7:0]    st_len, st_kind;
  logic [15:0]   st_handle;
  logic [47:0]   st_meta;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [PW:0]   diff;

  assign clear_ring = cfg_we_i && (cfg_idx_i == ftcr_pkg::CFG_MODE) &&
                      ((cfg_data_i[1:0] == ftcr_pkg::MODE_CAPTURE) ||
                       (cfg_data_i[1:0] == ftcr_pkg::MODE_PAIR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ftcr_pkg::MODE_OFF;
      filter_q    <= 1'b0;
      marker_q    <= 8'd10;
      nfc_kind_q  <= 8'd14;
      pair_kind_q <= 8'd12;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftcr_pkg::CFG_MODE:      mode_q      <= cfg_data_i[1:0];
        ftcr_pkg::CFG_FILTER:    filter_q    <= cfg_data_i[0];
        ftcr_pkg::CFG_MARKER:    marker_q    <= cfg_data_i;
        ftcr_pkg::CFG_NFC_STATE: nfc_kind_q  <= cfg_data_i;
        ftcr_pkg::CFG_PAIR_KIND: pair_kind_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rd_addr = AW'(AW'(rslot_q) * AW'(ftcr_pkg::MAX_BYTES)) + AW'(ridx_q);
  assign wr_addr = AW'(AW'(wslot_q) * AW'(ftcr_pkg::MAX_BYTES)) + AW'(widx_q);

  // reads issued in the transfer cycle, used in the run cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_q      <= item_i;
      time_rd_q <= time_mem[tail_q];
      meta_rd_q <= meta_mem[tail_q];
      pay_rd_q  <= pay_mem[rd_addr];
    end
  end

  always_comb begin
    is_hdr    = it_q.operation == ftcr_pkg::OP_HDR;
    is_pair   = it_q.operation == ftcr_pkg::OP_PAIR;
    pass_hdr  = (mode_q == ftcr_pkg::MODE_CAPTURE) &&
                (!filter_q || ftcr_pkg::nfc_handle(it_q.handle) ||
                 (it_q.kind == nfc_kind_q) || (it_q.kind == marker_q));
    pass_pair = (mode_q == ftcr_pkg::MODE_PAIR) &&
                (it_q.record_len <= 16'(ftcr_pkg::MAX_BYTES));
    store     = cmd_i.exec && ((is_hdr && pass_hdr) || (is_pair && pass_pair));
    byte_ok   = (it_q.operation == ftcr_pkg::OP_BYTE) && (widx_q < wlen_q);
    drain_ok  = (it_q.operation == ftcr_pkg::OP_DRAIN_HDR) && (tail_q != head_q);
    rbyte_ok  = (it_q.operation == ftcr_pkg::OP_DRAIN_BYTE) && (ridx_q < rlen_q);
    head_nx   = ftcr_pkg::ptr_inc(head_q);
    full      = head_nx == tail_q;
    st_len    = (it_q.record_len > 16'(ftcr_pkg::MAX_BYTES)) ? 8'(ftcr_pkg::MAX_BYTES)
                                                             : it_q.record_len[7:0];
    st_kind   = is_hdr ? it_q.kind : pair_kind_q;
    st_handle = is_hdr ? it_q.handle : 16'd0;
    st_meta   = {st_kind, st_handle, it_q.record_len, st_len};

    head_d  = head_q;
    tail_d  = tail_q;
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    widx_d  = widx_q;
    ridx_d  = ridx_q;
    wlen_d  = wlen_q;
    rlen_d  = rlen_q;
    drop_d  = drop_q;

    if (clear_ring) begin
      head_d = '0;
      tail_d = '0;
      drop_d = '0;
      widx_d = ftcr_pkg::IDX_NONE;
      ridx_d = ftcr_pkg::IDX_NONE;
    end else if (cmd_i.exec) begin
      if (store) begin
        if (full) begin
          tail_d = ftcr_pkg::ptr_inc(tail_q);
          drop_d = drop_q + 32'd1;
        end
        wslot_d = head_q;
        widx_d  = 8'd0;
        wlen_d  = st_len;
        head_d  = head_nx;
        // a new record over the slot being drained changes its length
        if (head_q == rslot_q) rlen_d = st_len;
      end else if (is_hdr || is_pair) begin
        widx_d = ftcr_pkg::IDX_NONE;
      end else if (byte_ok) begin
        widx_d = widx_q + 8'd1;
      end else if (drain_ok) begin
        rslot_d = tail_q;
        ridx_d  = 8'd0;
        rlen_d  = meta_rd_q[7:0];
        tail_d  = ftcr_pkg::ptr_inc(tail_q);
      end else if (rbyte_ok) begin
        ridx_d = ridx_q + 8'd1;
      end
    end

    diff = {1'b0, head_d} + (PW+1)'(ftcr_pkg::RING_DEPTH) - {1'b0, tail_d};
    if (diff >= (PW+1)'(ftcr_pkg::RING_DEPTH)) diff = diff - (PW+1)'(ftcr_pkg::RING_DEPTH);

    res_d                = '0;
    res_d.accepted       = store || byte_ok;
    res_d.entry_valid    = drain_ok || rbyte_ok;
    if (drain_ok) begin
      res_d.entry_kind       = meta_rd_q[47:40];
      res_d.entry_handle     = meta_rd_q[39:24];
      res_d.entry_orig_len   = meta_rd_q[23:8];
      res_d.entry_stored_len = meta_rd_q[7:0];
      res_d.entry_time_us    = time_rd_q;
    end
    if (rbyte_ok) res_d.data_out = pay_rd_q;
    res_d.buffered_count = 7'(diff);
    res_d.dropped_count  = drop_d;
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      time_mem[head_q] <= it_q.timestamp_us;
      meta_mem[head_q] <= st_meta;
    end
    if (cmd_i.exec && byte_ok) pay_mem[wr_addr] <= it_q.data_byte;
    if (cmd_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      wslot_q     <= '0;
      rslot_q     <= '0;
      widx_q      <= '0;
      ridx_q      <= '0;
      wlen_q      <= '0;
      rlen_q      <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      widx_q  <= widx_d;
      ridx_q  <= ridx_d;
      wlen_q  <= wlen_d;
      rlen_q  <= rlen_d;
      drop_q  <= drop_d;
      if (cmd_i.exec) out_valid_q <= 1'b1;
      else if (cmd_i.take) out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign result_o          = res_q;

endmodule

[src/filtered_trace_capture_ring.sv]
// top level of the filtered trace capture ring
// Trace capture ring holding up to RING_DEPTH-1 timestamped records, each with
// kind, handle, original length and up to MAX_BYTES payload bytes; when full the
// oldest record is overwritten and the drop count goes up. Every input transfer
// yields exactly one result transfer. An item passes the idle and run states:
// the transfer in idle issues the synchronous reads of the header and payload
// stores, and the run state updates the pointers, writes the stores and loads
// the result register once a waiting result has been taken. No new item is taken
// until the last is committed; a waiting result holds the next item in run. No
// clearing pass is needed after reset. Settings are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; writing capture mode 1 or 2
// empties the ring and zeroes the drop count.
`include "filtered_trace_capture_ring_defines.svh"

module filtered_trace_capture_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ftcr_in_if.sink                         in_ch_i,
  ftcr_out_if.source                      out_ch_o,
  input  logic                            cfg_we_i,
  input  logic [ftcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ftcr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ftcr_pkg::cmd_t     cmd;
  ftcr_pkg::status_t  status;
  ftcr_pkg::in_item_t item;
  ftcr_pkg::result_t  res;
  logic               in_ready;
  logic               out_valid;

  // pack the input transfer payload
  assign item.operation    = in_ch_i.operation;
  assign item.kind         = in_ch_i.kind;
  assign item.handle       = in_ch_i.handle;
  assign item.record_len   = in_ch_i.record_len;
  assign item.timestamp_us = in_ch_i.timestamp_us;
  assign item.data_byte    = in_ch_i.data_byte;

  // sequencer: idle takes the transfer, run commits the item
  ftcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  // ring pointers, stores and the result register
  ftcr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status),
    .out_valid_o (out_valid),
    .result_o    (res)
  );

  assign in_ch_i.ready             = in_ready;
  assign out_ch_o.valid            = out_valid;
  assign out_ch_o.accepted         = res.accepted;
  assign out_ch_o.entry_valid      = res.entry_valid;
  assign out_ch_o.entry_kind       = res.entry_kind;
  assign out_ch_o.entry_handle     = res.entry_handle;
  assign out_ch_o.entry_time_us    = res.entry_time_us;
  assign out_ch_o.entry_orig_len   = res.entry_orig_len;
  assign out_ch_o.entry_stored_len = res.entry_stored_len;
  assign out_ch_o.data_out         = res.data_out;
  assign out_ch_o.buffered_count   = res.buffered_count;
  assign out_ch_o.dropped_count    = res.dropped_count;

  // an accepted item is committed before another transfer is taken
  `FTCR_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_ch_i.valid && in_ready, !in_ready)
  // a result never reports both a store and a drain
  `FTCR_ASSERT_NOW(a_store_or_drain, clk_i, rst_ni, out_valid, !(res.accepted && res.entry_valid))
  // drained data only comes with a valid drain
  `FTCR_ASSERT_NOW(a_data_needs_valid, clk_i, rst_ni, out_valid && (res.data_out != 8'd0),
                   res.entry_valid)

endmodule
